@@ rtl/dlnav_pkg.sv @@
// ----------------------------------------------------------------------------
// dlnav_pkg
// Shared types and constants of the debounced list navigator: register
// indexes, reset values, field widths and the click group between modules.
// ----------------------------------------------------------------------------
package dlnav_pkg;

    // Number of debounced buttons (up, down, select, back)
    localparam int NUM_BUTTONS = 4;

    // Field widths
    localparam int TIME_W     = 32;
    localparam int DEBOUNCE_W = 16;
    localparam int ROWS_W     = 5;
    localparam int INDEX_W    = 8;

    // Stream widths, whole bytes
    localparam int S_DATA_W = 48;
    localparam int M_DATA_W = 24;

    // Register reset values
    localparam logic [DEBOUNCE_W-1:0] DEBOUNCE_RESET = 16'd35;
    localparam logic [ROWS_W-1:0]     ROWS_RESET     = 5'd5;

    // Largest list the menu handles
    localparam int MAX_ENTRIES = 256;

    // Entry count ceiling as seen by the cursor logic (entry_count is 8 bits)
    localparam logic [INDEX_W:0] COUNT_CAP =
        (MAX_ENTRIES > 255) ? 9'd255 : 9'(MAX_ENTRIES);

    // Configuration register indexes
    typedef enum logic [0:0] {
        CFG_DEBOUNCE_TIME = 1'b0,
        CFG_VISIBLE_ROWS  = 1'b1
    } cfg_index_t;

    // Clicks produced by the debouncer for one sample
    typedef struct packed {
        logic back_click;
        logic select_click;
        logic down_click;
        logic up_click;
    } btn_click_t;

endpackage

@@ rtl/dlnav_debounce.sv @@
// ----------------------------------------------------------------------------
// dlnav_debounce
// Timestamp debouncer for the four buttons. Tracks the last raw level, the
// time of its last change and the stable level, and flags a click when a
// button settles to pressed.
// ----------------------------------------------------------------------------
module dlnav_debounce
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 step,
    input  logic [dlnav_pkg::TIME_W-1:0]         now_ms,
    input  logic [dlnav_pkg::NUM_BUTTONS-1:0]    raw,
    input  logic [dlnav_pkg::DEBOUNCE_W-1:0]     debounce_time,
    output dlnav_pkg::btn_click_t                click
);
    import dlnav_pkg::*;

    logic [NUM_BUTTONS-1:0] raw_last_reg;
    logic [NUM_BUTTONS-1:0] raw_last_next;
    logic [NUM_BUTTONS-1:0] stable_reg;
    logic [NUM_BUTTONS-1:0] stable_next;
    logic [TIME_W-1:0]      change_time_reg [NUM_BUTTONS];
    logic [TIME_W-1:0]      change_time_next [NUM_BUTTONS];
    logic [NUM_BUTTONS-1:0] click_vec;

    // Per button: restart the timer on a raw change, settle after the hold time
    always_comb
    begin
        logic [TIME_W-1:0] held;
        for (int b = 0; b < NUM_BUTTONS; b++)
        begin
            raw_last_next[b]    = raw_last_reg[b];
            change_time_next[b] = change_time_reg[b];
            stable_next[b]      = stable_reg[b];
            click_vec[b]        = 1'b0;
            if (raw[b] != raw_last_reg[b])
            begin
                raw_last_next[b]    = raw[b];
                change_time_next[b] = now_ms;
            end
            held = now_ms - change_time_next[b];
            if ((held >= {{(TIME_W-DEBOUNCE_W){1'b0}}, debounce_time}) &&
                (stable_reg[b] != raw_last_next[b]))
            begin
                stable_next[b] = raw_last_next[b];
                click_vec[b]   = raw_last_next[b];
            end
        end
    end

    assign click.up_click     = step & click_vec[0];
    assign click.down_click   = step & click_vec[1];
    assign click.select_click = step & click_vec[2];
    assign click.back_click   = step & click_vec[3];

    // Advance button state once per processed sample
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            raw_last_reg <= '0;
            stable_reg   <= '0;
            for (int b = 0; b < NUM_BUTTONS; b++)
            begin
                change_time_reg[b] <= '0;
            end
        end
        else if (step)
        begin
            raw_last_reg <= raw_last_next;
            stable_reg   <= stable_next;
            for (int b = 0; b < NUM_BUTTONS; b++)
            begin
                change_time_reg[b] <= change_time_next[b];
            end
        end
    end

    // Button state moves only on a processed sample
    a_hold_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !step |=> $stable(stable_reg) && $stable(raw_last_reg))
        else $error("debouncer state changed without a sample");

    // A click means the button is now stable pressed
    a_click_pressed: assert property (@(posedge clk) disable iff (!rst_n)
        click.up_click |=> stable_reg[0])
        else $error("up click without stable press");

    // A click is a change of stable level
    a_click_edge: assert property (@(posedge clk) disable iff (!rst_n)
        click.select_click |-> !stable_reg[2])
        else $error("select click while already stable pressed");

endmodule

@@ rtl/debounced_list_navigator.sv @@
// ----------------------------------------------------------------------------
// debounced_list_navigator
// Debounces four buttons by timestamp and drives a scrolling list menu with
// a cursor, a window start, a detail view and a redraw flag.
// ----------------------------------------------------------------------------
// Path: the input register loads a sample when it is accepted, and the result
// register loads that sample's result when the input register advances.
// Throughput: one sample per cycle; the result register frees while the
// next sample is in the input register, so stalls only when m_tready is low.
// Reset: all button, menu and snapshot state clears; debounce_time returns
// to 35 and visible_rows to 5; the first result always asks for a redraw.
module debounced_list_navigator
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    // s_tdata: now_ms[31:0], up_pressed[32], down_pressed[33],
    // select_pressed[34], back_pressed[35], scan_found[36],
    // entry_count[44:37], zero fill [47:45]
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [dlnav_pkg::S_DATA_W-1:0]       s_tdata,
    // m_tdata: cursor[7:0], window_first[15:8], detail_mode[16],
    // scan_done[17], redraw[18], zero fill [23:19]
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [dlnav_pkg::M_DATA_W-1:0]       m_tdata,
    input  logic                                 cfg_we,
    input  logic                                 cfg_index,
    input  logic [dlnav_pkg::DEBOUNCE_W-1:0]     cfg_wdata
);
    import dlnav_pkg::*;

    // Configuration registers
    logic [DEBOUNCE_W-1:0] debounce_reg;
    logic [ROWS_W-1:0]     rows_reg;

    // Input register
    logic                   in_valid_reg;
    logic [TIME_W-1:0]      now_reg;
    logic [NUM_BUTTONS-1:0] raw_reg;
    logic                   scan_found_reg;
    logic [INDEX_W-1:0]     count_reg;

    // Menu state
    logic [INDEX_W-1:0] cursor_reg, cursor_next;
    logic [INDEX_W-1:0] window_reg, window_next;
    logic               detail_reg, detail_next;
    logic               scan_latch_reg, scan_latch_next;
    logic [17:0]        snap_reg, snap_next;
    logic               snap_valid_reg;
    logic               redraw;

    // Result register
    logic               out_valid_reg;
    logic [M_DATA_W-1:0] out_data_reg;

    logic       advance;
    logic [ROWS_W-1:0]  rows_eff;
    logic [INDEX_W:0]   count_eff;
    logic [INDEX_W:0]   cursor_inc;
    logic [INDEX_W-1:0] cursor_dec;
    logic [INDEX_W:0]   window_end;
    btn_click_t         click;

    assign advance  = in_valid_reg & (~out_valid_reg | m_tready);
    assign s_tready = ~in_valid_reg | advance;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            debounce_reg <= DEBOUNCE_RESET;
            rows_reg     <= ROWS_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index_t'(cfg_index))
                CFG_DEBOUNCE_TIME: debounce_reg <= cfg_wdata;
                CFG_VISIBLE_ROWS:  rows_reg     <= cfg_wdata[ROWS_W-1:0];
                default:           debounce_reg <= debounce_reg;
            endcase
        end
    end

    // Capture the incoming sample
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            now_reg        <= s_tdata[31:0];
            raw_reg        <= s_tdata[35:32];
            scan_found_reg <= s_tdata[36];
            count_reg      <= s_tdata[44:37];
        end
    end

    dlnav_debounce u_debounce
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .step          (advance),
        .now_ms        (now_reg),
        .raw           (raw_reg),
        .debounce_time (debounce_reg),
        .click         (click)
    );

    // Menu update: first click in priority order wins
    always_comb
    begin
        rows_eff   = (rows_reg == '0) ? ROWS_W'(1) : rows_reg;
        count_eff  = ({1'b0, count_reg} > COUNT_CAP) ? COUNT_CAP : {1'b0, count_reg};
        cursor_inc = {1'b0, cursor_reg} + 9'd1;
        cursor_dec = cursor_reg - 8'd1;
        window_end = {1'b0, window_reg} + {4'b0, rows_eff};

        cursor_next     = cursor_reg;
        window_next     = window_reg;
        detail_next     = detail_reg;
        scan_latch_next = scan_latch_reg | scan_found_reg;

        if (click.up_click && !detail_reg)
        begin
            if (cursor_reg != '0)
            begin
                cursor_next = cursor_dec;
                if (cursor_dec < window_reg)
                begin
                    window_next = window_reg - 8'd1;
                end
            end
        end
        else if (click.down_click && !detail_reg)
        begin
            if (cursor_inc < count_eff)
            begin
                cursor_next = cursor_inc[INDEX_W-1:0];
                if (cursor_inc >= window_end)
                begin
                    window_next = window_reg + 8'd1;
                end
            end
        end
        else if (click.select_click)
        begin
            if (!detail_reg)
            begin
                if (scan_latch_next && (count_eff != '0))
                begin
                    detail_next = 1'b1;
                end
            end
            else
            begin
                detail_next = 1'b0;
            end
        end
        else if (click.back_click)
        begin
            detail_next = 1'b0;
        end

        snap_next = {scan_latch_next, detail_next, window_next, cursor_next};
        redraw    = ~snap_valid_reg | (snap_next != snap_reg);
    end

    // Commit menu state and the drawn snapshot
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cursor_reg     <= '0;
            window_reg     <= '0;
            detail_reg     <= 1'b0;
            scan_latch_reg <= 1'b0;
            snap_reg       <= '0;
            snap_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            cursor_reg     <= cursor_next;
            window_reg     <= window_next;
            detail_reg     <= detail_next;
            scan_latch_reg <= scan_latch_next;
            if (redraw)
            begin
                snap_reg       <= snap_next;
                snap_valid_reg <= 1'b1;
            end
        end
    end

    // Result register: load on advance, drop when taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_data_reg <= {5'b0, redraw, snap_next};
        end
    end

    // The window never starts past the cursor
    a_window_le_cursor: assert property (@(posedge clk) disable iff (!rst_n)
        window_reg <= cursor_reg)
        else $error("window start beyond cursor");

    // Detail view is only reachable after a scan completed
    a_detail_needs_scan: assert property (@(posedge clk) disable iff (!rst_n)
        detail_reg |-> scan_latch_reg)
        else $error("detail view without scan result");

    // The cursor moves at most one entry per sample
    a_cursor_step: assert property (@(posedge clk) disable iff (!rst_n)
        ##1 (cursor_reg == $past(cursor_reg) ||
             {1'b0, cursor_reg} == {1'b0, $past(cursor_reg)} + 9'd1 ||
             {1'b0, cursor_reg} + 9'd1 == {1'b0, $past(cursor_reg)}))
        else $error("cursor jumped");

    // A result whose state differs from the snapshot must request a redraw
    a_redraw_on_change: assert property (@(posedge clk) disable iff (!rst_n)
        advance && snap_valid_reg && (snap_next != snap_reg) |=> out_data_reg[18])
        else $error("state change without redraw");

endmodule
